>>> src/bab_pkg.sv
// Package for the bearing block: widths, CORDIC angle table and shared types.
`default_nettype none
package bab_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int ITERATIONS  = 16;

  localparam int TABLE_LEN  = 32;
  localparam int TABLE_BITS = 32;
  localparam int NORM_TOP   = 40;

  localparam int DW  = COORD_WIDTH + 1;             // coordinate difference
  localparam int MW  = COORD_WIDTH;                 // magnitude of a difference
  localparam int PW  = $clog2(MW);                  // msb position
  localparam int SW  = $clog2(NORM_TOP + 1);        // normalize shift
  localparam int XW  = NORM_TOP + 4;                // CORDIC x/y datapath
  localparam int ZW  = TABLE_BITS + 2;              // CORDIC angle accumulator
  localparam int IW  = $clog2(TABLE_LEN);           // cell index
  localparam int CW  = TABLE_BITS - 1;              // clamped angle
  localparam int RSH = (TABLE_BITS > ANGLE_WIDTH) ? TABLE_BITS - ANGLE_WIDTH : 0;

  localparam int IN_TW  = ((4 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_TW = ((ANGLE_WIDTH + 7) / 8) * 8;

  localparam logic [ANGLE_WIDTH-1:0] ANG_HALF    = ANGLE_WIDTH'(64'd1 << (ANGLE_WIDTH - 1));
  localparam logic [ANGLE_WIDTH-1:0] ANG_QUARTER = ANGLE_WIDTH'(64'd1 << (ANGLE_WIDTH - 2));
  localparam logic [ANGLE_WIDTH-1:0] ANG_3QUARTER = ANG_HALF + ANG_QUARTER;

  localparam logic [TABLE_BITS-1:0] ATAN_TBL [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335086,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41721,
    32'd20860,     32'd10430,     32'd5215,      32'd2607,     32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81,       32'd40,
    32'd20,        32'd10,        32'd5,         32'd2,        32'd1,
    32'd0,         32'd0
  };

  // sideband carried alongside the CORDIC data
  typedef struct packed {
    logic                   spec;   // point on an axis, result is sval
    logic [ANGLE_WIDTH-1:0] sval;
    logic                   dx_neg;
    logic                   dy_neg;
  } tag_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    tag_t                 tag;
  } cell_t;

endpackage
`default_nettype wire

>>> src/bab_prep.sv
// Front end: coordinate differences, magnitudes, axis cases and normalization.
`default_nettype none
module bab_prep (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    en,
  input  wire                                    in_vld,
  input  wire logic signed [bab_pkg::COORD_WIDTH-1:0] ax,
  input  wire logic signed [bab_pkg::COORD_WIDTH-1:0] ay,
  input  wire logic signed [bab_pkg::COORD_WIDTH-1:0] bx,
  input  wire logic signed [bab_pkg::COORD_WIDTH-1:0] by,
  output logic                                   out_vld,
  output bab_pkg::cell_t                         out_cell
);
  import bab_pkg::*;

  localparam logic [SW-1:0] NT = SW'(NORM_TOP);

  logic [3:0] vld_r;

  // stage 1
  logic signed [DW-1:0] dx_r, dy_r;
  // stage 2
  logic [MW-1:0] mx_r, my_r, big_r;
  tag_t          tag2_r;
  logic [MW-1:0] mx_nxt, my_nxt;
  tag_t          tag2_nxt;
  // stage 3
  logic [MW-1:0] mx3_r, my3_r;
  logic [SW-1:0] sh_r;
  tag_t          tag3_r;
  logic [PW-1:0] msb;
  // stage 4
  cell_t         cell_r;
  logic [XW-1:0] xs, ys;

  always_comb begin
    logic [DW-1:0] ndx, ndy;
    ndx = -dx_r;
    ndy = -dy_r;
    mx_nxt = dx_r[DW-1] ? ndx[MW-1:0] : dx_r[MW-1:0];
    my_nxt = dy_r[DW-1] ? ndy[MW-1:0] : dy_r[MW-1:0];
    tag2_nxt.dx_neg = dx_r[DW-1];
    tag2_nxt.dy_neg = dy_r[DW-1];
    tag2_nxt.spec   = (dx_r == '0) || (dy_r == '0);
    if (dx_r == '0) begin
      tag2_nxt.sval = dy_r[DW-1] ? ANG_HALF : '0;
    end else if (dx_r[DW-1]) begin
      tag2_nxt.sval = ANG_3QUARTER;
    end else begin
      tag2_nxt.sval = ANG_QUARTER;
    end
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < MW; i++) begin
      if (big_r[i]) msb = PW'(i);
    end
  end

  assign xs = XW'(my3_r) << sh_r;
  assign ys = XW'(mx3_r) << sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= DW'(bx) - DW'(ax);
      dy_r   <= DW'(by) - DW'(ay);
      mx_r   <= mx_nxt;
      my_r   <= my_nxt;
      big_r  <= (mx_nxt > my_nxt) ? mx_nxt : my_nxt;
      tag2_r <= tag2_nxt;
      mx3_r  <= mx_r;
      my3_r  <= my_r;
      sh_r   <= NT - SW'(msb);
      tag3_r <= tag2_r;
      cell_r.x   <= $signed(xs);
      cell_r.y   <= $signed(ys);
      cell_r.z   <= '0;
      cell_r.tag <= tag3_r;
    end
  end

  assign out_vld  = vld_r[3];
  assign out_cell = cell_r;

endmodule
`default_nettype wire

>>> src/bab_cell.sv
// One CORDIC vectoring cell: a single micro-rotation and its register.
`default_nettype none
module bab_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         en,
  input  wire logic [bab_pkg::IW-1:0] idx,
  input  wire                         in_vld,
  input  wire bab_pkg::cell_t         in_cell,
  output logic                        out_vld,
  output bab_pkg::cell_t              out_cell
);
  import bab_pkg::*;

  logic                 vld_r;
  cell_t                cell_r;
  cell_t                cell_nxt;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] da;

  assign xs = in_cell.x >>> idx;
  assign ys = in_cell.y >>> idx;
  assign da = $signed(ZW'(ATAN_TBL[idx]));

  always_comb begin
    cell_nxt.tag = in_cell.tag;
    if (!in_cell.y[XW-1]) begin
      cell_nxt.x = in_cell.x + ys;
      cell_nxt.y = in_cell.y - xs;
      cell_nxt.z = in_cell.z + da;
    end else begin
      cell_nxt.x = in_cell.x - ys;
      cell_nxt.y = in_cell.y + xs;
      cell_nxt.z = in_cell.z - da;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_cell = cell_r;

endmodule
`default_nettype wire

>>> src/bab_post.sv
// Back end: angle clamp and rounding, then quadrant mapping to the bearing.
`default_nettype none
module bab_post (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   en,
  input  wire                                   in_vld,
  input  wire bab_pkg::cell_t                   in_cell,
  output logic                                  out_vld,
  output logic [bab_pkg::ANGLE_WIDTH-1:0]       bearing
);
  import bab_pkg::*;

  localparam logic signed [ZW-1:0] ZQ  = ZW'(64'd1 << (TABLE_BITS - 2));
  localparam logic [TABLE_BITS-1:0] RND =
    (RSH > 0) ? TABLE_BITS'(64'd1 << (RSH - 1)) : '0;

  logic [1:0]             vld_r;
  logic [ANGLE_WIDTH-1:0] t_r;
  tag_t                   tag_r;
  logic [ANGLE_WIDTH-1:0] bearing_r;
  logic [CW-1:0]          zc;
  logic [TABLE_BITS-1:0]  zsum;
  logic [ANGLE_WIDTH-1:0] t_nxt;
  logic [ANGLE_WIDTH-1:0] r_nxt;

  always_comb begin
    if (in_cell.z[ZW-1]) begin
      zc = '0;
    end else if (in_cell.z > ZQ) begin
      zc = CW'(ZQ);
    end else begin
      zc = in_cell.z[CW-1:0];
    end
    zsum  = TABLE_BITS'(zc) + RND;
    t_nxt = ANGLE_WIDTH'(zsum >> RSH);
  end

  always_comb begin
    if (tag_r.spec) begin
      r_nxt = tag_r.sval;
    end else if (!tag_r.dx_neg && !tag_r.dy_neg) begin
      r_nxt = t_r;
    end else if (!tag_r.dx_neg) begin
      r_nxt = ANG_HALF - t_r;
    end else if (tag_r.dy_neg) begin
      r_nxt = ANG_HALF + t_r;
    end else begin
      r_nxt = '0 - t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r       <= t_nxt;
      tag_r     <= in_cell.tag;
      bearing_r <= r_nxt;
    end
  end

  assign out_vld = vld_r[1];
  assign bearing = bearing_r;

`ifndef SYNTHESIS
  a_t_quarter: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> t_r <= ANG_QUARTER)
    else $error("rounded angle above a quarter turn");
  a_spec_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && tag_r.spec) |-> tag_r.sval[ANGLE_WIDTH-3:0] == '0)
    else $error("axis result not a multiple of a quarter turn");
`endif

endmodule
`default_nettype wire

>>> src/bearing_angle_between_points.sv
// Top level: bearing from point A to point B through a pipelined CORDIC chain.
// Takes one point pair per cycle while in_tready is high and returns one bearing per pair,
// clockwise from +y, with 2^ANGLE_WIDTH units per turn. From the accepted request to
// out_tvalid lie 4 front-end stages, one CORDIC cell per iteration, 2 back-end stages and
// the output register; the row of CORDIC cells makes up most of that path. A two-entry
// output buffer absorbs a stalled consumer; in_tready drops only once both entries are full,
// and the pipeline then holds.
`default_nettype none
module bearing_angle_between_points (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // first_x, first_y, second_x, second_y
  input  wire logic [bab_pkg::IN_TW-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // bearing
  output logic [bab_pkg::OUT_TW-1:0]         out_tdata
);
  import bab_pkg::*;

  logic                   en;
  logic                   cv   [ITERATIONS+1];
  cell_t                  cc   [ITERATIONS+1];
  logic                   res_vld;
  logic [ANGLE_WIDTH-1:0] res;
  logic                   out_vld_r, skid_vld_r;
  logic [ANGLE_WIDTH-1:0] out_r, skid_r;
  logic                   push;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  bab_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid && in_tready),
    .ax       ($signed(in_tdata[COORD_WIDTH-1:0])),
    .ay       ($signed(in_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
    .bx       ($signed(in_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH])),
    .by       ($signed(in_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH])),
    .out_vld  (cv[0]),
    .out_cell (cc[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    bab_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .idx      (IW'(i)),
      .in_vld   (cv[i]),
      .in_cell  (cc[i]),
      .out_vld  (cv[i+1]),
      .out_cell (cc[i+1])
    );
  end

  bab_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (cv[ITERATIONS]),
    .in_cell (cc[ITERATIONS]),
    .out_vld (res_vld),
    .bearing (res)
  );

  assign push = en && res_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= push;
      end
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_tready) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TW'(out_r);

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("buffer entry held with empty output register");
  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("buffer entry filled without a stalled output");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |=> !(skid_vld_r && $past(push)))
    else $error("result pushed while buffer full");
`endif

endmodule
`default_nettype wire
